>>> hw/rtl/zvj_pkg.sv
// Package for the shaped jerk-limited trajectory generator: widths, codes,
// word types, unit request/response structs and fixed-point helpers.
// No dependencies; used by the generator, the multiplier and the divider.
`default_nettype none

package zvj_pkg;

  localparam int unsigned QW   = 32;  // Q16.16 data word
  localparam int unsigned TW   = 31;  // unsigned time / jerk magnitude
  localparam int unsigned KW   = 17;  // leading fraction, Q1.16
  localparam int unsigned SW   = 16;  // sample period
  localparam int unsigned FRAC = 16;  // fraction bits
  localparam int unsigned MW   = 48;  // operand magnitude width of the multiplier
  localparam int unsigned HW   = MW / 2;
  localparam int unsigned VW   = MW + 1;  // signed term width
  localparam int unsigned BW   = QW + 1;  // signed second operand width
  localparam int unsigned PW   = MW + QW; // full product width
  localparam int unsigned AW   = 53;  // exact sum width
  localparam int unsigned CW   = 31;  // config data width

  localparam logic [TW-1:0]   JERK_MAX_RST = TW'(65536);
  localparam logic [TW-1:0]   SHAPER_RST   = TW'(3277);
  localparam logic [KW-1:0]   KAPPA_RST    = KW'(32768);
  localparam logic [SW-1:0]   STEP_RST     = SW'(66);
  localparam logic [KW-1:0]   Q_ONE        = KW'(65536);
  localparam logic [TW-1:0]   TIME_MAX     = '1;
  localparam logic [TW-1:0]   ZERO_SPAN    = TW'(3277);
  localparam logic [MW-2:0]   TERM_MAX     = '1;

  typedef enum logic [1:0] {
    REG_JERK_MAX     = 2'd0,
    REG_SHAPER_DELAY = 2'd1,
    REG_KAPPA_LEAD   = 2'd2,
    REG_TIME_STEP    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_e;

  typedef struct packed {
    logic                 kind;
    logic signed [QW-1:0] target_accel;
    logic signed [QW-1:0] start_position;
    logic signed [QW-1:0] start_velocity;
    logic signed [QW-1:0] start_accel;
  } in_item_t;

  typedef struct packed {
    logic [TW-1:0]        sample_time;
    logic signed [QW-1:0] jerk_out;
    logic signed [QW-1:0] accel_out;
    logic signed [QW-1:0] velocity_out;
    logic signed [QW-1:0] position_out;
    logic                 done_res;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic                 round;
    logic signed [VW-1:0] a;
    logic signed [BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [VW-1:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic          start;
    logic          div3;
    logic [MW-1:0] dividend;
    logic [TW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [MW-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [QW-1:0] sat32(input logic signed [AW-1:0] v);
    logic fits;
    fits = (&v[AW-1:QW-1]) || ~(|v[AW-1:QW-1]);
    if (fits) return v[QW-1:0];
    return v[AW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
  endfunction

  // halve, truncating toward zero
  function automatic logic signed [VW-1:0] half(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] tmp;
    tmp = v + $signed(VW'(v[VW-1]));
    return tmp >>> 1;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/zvj_stream_if.sv
// Valid/ready stream interface carrying one word of a chosen payload type.
// Depends on nothing; payload types come from zvj_pkg at instantiation.
`default_nettype none

interface zvj_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/zv_jerk_profile_generator.sv
// Shaped jerk-limited trajectory generator, top level: sequencer over one shared
// multiplier and one shared divider. Start word: the 48-step divide, then one multiply.
// Tick word: three multiplies, then for each active impulse (0..4) three more multiplies
// and a divide by three, then the finish step.
// One word at a time; ready only when idle. A result may wait in the output register.
// Reset (async, active low) restores the register defaults and leaves the block idle.
`default_nettype none

module zv_jerk_profile_generator (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [zvj_pkg::CW-1:0] cfg_data_i,
  zvj_stream_if.sink                in_i,
  zvj_stream_if.source              out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SDIV, S_SMUL, S_TCHK, S_MAT, S_MVT, S_MATT,
    S_KJA, S_KJV, S_KJP, S_KD3, S_FIN
  } state_e;

  state_e                        state_q;
  logic                          pend_q, run_q, ov_q, d3neg_q;
  logic [zvj_pkg::TW-1:0]        jm_q, tv_q, t_q, end_q, delta_q;
  logic [zvj_pkg::KW-1:0]        kap_q;
  logic [zvj_pkg::SW-1:0]        ts_q;
  logic [2:0]                    ac_q;
  logic [1:0]                    k_q;
  logic [zvj_pkg::TW-1:0]        tim_q [4];
  logic signed [zvj_pkg::QW-1:0] jrk_q [4];
  logic signed [zvj_pkg::QW-1:0] p0_q, v0_q, a0_q, tgt_q;
  logic signed [zvj_pkg::VW-1:0] at_q, ja_q, jv_q;
  logic signed [zvj_pkg::AW-1:0] jsum_q, asum_q, vsum_q, psum_q;
  zvj_pkg::out_item_t            out_q;

  zvj_pkg::mul_req_t             mreq;
  zvj_pkg::mul_rsp_t             mrsp;
  zvj_pkg::div_req_t             dreq;
  zvj_pkg::div_rsp_t             drsp;

  logic [zvj_pkg::TW-1:0]        jm_eff, tim_rd, end_n, delta_n, t_next, j0, j1;
  logic [zvj_pkg::KW-1:0]        k0;
  logic [zvj_pkg::SW-1:0]        ts_eff;
  logic [1:0]                    rd_idx;
  logic signed [zvj_pkg::QW-1:0] jrk_rd, d;
  logic [zvj_pkg::QW-1:0]        tmag;
  logic signed [zvj_pkg::BW-1:0] tb;
  logic signed [zvj_pkg::VW-1:0] mhalf;
  logic signed [zvj_pkg::AW-1:0] q3;
  logic [zvj_pkg::TW-1:0]        tim_n [4];
  logic signed [zvj_pkg::QW-1:0] jrk_n [4];
  logic                          mul_st, fin_go, done_now;

  zvj_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));
  zvj_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jm_q  <= zvj_pkg::JERK_MAX_RST;
      tv_q  <= zvj_pkg::SHAPER_RST;
      kap_q <= zvj_pkg::KAPPA_RST;
      ts_q  <= zvj_pkg::STEP_RST;
    end else if (cfg_we_i) begin
      unique case (zvj_pkg::cfg_reg_e'(cfg_idx_i))
        zvj_pkg::REG_JERK_MAX:     jm_q  <= cfg_data_i[zvj_pkg::TW-1:0];
        zvj_pkg::REG_SHAPER_DELAY: tv_q  <= cfg_data_i[zvj_pkg::TW-1:0];
        zvj_pkg::REG_KAPPA_LEAD:   kap_q <= cfg_data_i[zvj_pkg::KW-1:0];
        zvj_pkg::REG_TIME_STEP:    ts_q  <= cfg_data_i[zvj_pkg::SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    jm_eff = (jm_q == '0) ? zvj_pkg::TW'(1) : jm_q;
    ts_eff = (ts_q == '0) ? zvj_pkg::SW'(1) : ts_q;
    k0     = (kap_q > zvj_pkg::Q_ONE) ? zvj_pkg::Q_ONE : kap_q;
    rd_idx = (state_q == S_TCHK) ? ac_q[1:0] : k_q;
    tim_rd = tim_q[rd_idx];
    jrk_rd = jrk_q[rd_idx];
    d      = $signed({1'b0, t_q}) - $signed({1'b0, tim_rd});
    tb     = $signed(zvj_pkg::BW'(t_q));
    tmag   = tgt_q[zvj_pkg::QW-1] ? zvj_pkg::QW'(-tgt_q) : zvj_pkg::QW'(tgt_q);
    mhalf  = zvj_pkg::half(mrsp.res);
    q3     = zvj_pkg::AW'($signed({1'b0, drsp.quot}));
    q3     = d3neg_q ? -q3 : q3;
    delta_n = (|drsp.quot[zvj_pkg::MW-1:zvj_pkg::TW]) ? zvj_pkg::TIME_MAX
                                                      : drsp.quot[zvj_pkg::TW-1:0];
    t_next = ({1'b0, t_q} + zvj_pkg::QW'(ts_eff) > zvj_pkg::QW'(zvj_pkg::TIME_MAX))
             ? zvj_pkg::TIME_MAX : t_q + zvj_pkg::TW'(ts_eff);
    done_now = t_q >= end_q;
    fin_go   = !ov_q || out_o.ready;
  end

  // impulse table built from delta, the shaper delay and the rounded lead jerk
  always_comb begin
    logic [zvj_pkg::QW-1:0] esum;
    logic                   neg;
    esum  = zvj_pkg::QW'(tv_q) + zvj_pkg::QW'(delta_q);
    end_n = esum[zvj_pkg::QW-1] ? zvj_pkg::TIME_MAX : esum[zvj_pkg::TW-1:0];
    j0    = mrsp.res[zvj_pkg::TW-1:0];
    j1    = jm_eff - j0;
    neg   = tgt_q[zvj_pkg::QW-1];
    tim_n[0] = '0;
    tim_n[3] = end_n;
    if (tgt_q == '0) begin
      tim_n[1] = '0;
      tim_n[2] = '0;
      tim_n[3] = zvj_pkg::ZERO_SPAN;
      for (int i = 0; i < 4; i++) jrk_n[i] = '0;
    end else if (tv_q < delta_q) begin
      tim_n[1] = tv_q;
      tim_n[2] = delta_q;
      jrk_n[0] = $signed({1'b0, j0});
      jrk_n[1] = $signed({1'b0, j1});
      jrk_n[2] = -$signed({1'b0, j0});
      jrk_n[3] = -$signed({1'b0, j1});
    end else begin
      tim_n[1] = delta_q;
      tim_n[2] = tv_q;
      jrk_n[0] = $signed({1'b0, j0});
      jrk_n[1] = -$signed({1'b0, j0});
      jrk_n[2] = $signed({1'b0, j1});
      jrk_n[3] = -$signed({1'b0, j1});
    end
    if (neg) begin
      for (int i = 0; i < 4; i++) jrk_n[i] = -jrk_n[i];
    end
  end

  // shared unit requests
  always_comb begin
    mul_st     = (state_q == S_SMUL) || (state_q == S_MAT) || (state_q == S_MVT) ||
                 (state_q == S_MATT) || (state_q == S_KJA) || (state_q == S_KJV) ||
                 (state_q == S_KJP);
    mreq.start = mul_st && !pend_q;
    mreq.round = state_q == S_SMUL;
    mreq.a     = '0;
    mreq.b     = zvj_pkg::BW'(d);
    unique case (state_q)
      S_SMUL: begin
        mreq.a = $signed(zvj_pkg::VW'(jm_eff));
        mreq.b = $signed(zvj_pkg::BW'(k0));
      end
      S_MAT: begin
        mreq.a = zvj_pkg::VW'(a0_q);
        mreq.b = tb;
      end
      S_MVT: begin
        mreq.a = zvj_pkg::VW'(v0_q);
        mreq.b = tb;
      end
      S_MATT: begin
        mreq.a = at_q;
        mreq.b = tb;
      end
      S_KJA: mreq.a = zvj_pkg::VW'(jrk_rd);
      S_KJV: mreq.a = ja_q;
      S_KJP: mreq.a = jv_q;
      default: ;
    endcase

    dreq.start    = ((state_q == S_SDIV) && !pend_q) || ((state_q == S_KJP) && mrsp.done);
    dreq.div3     = state_q == S_KJP;
    dreq.divisor  = jm_eff;
    dreq.dividend = (state_q == S_SDIV) ? {tmag, {zvj_pkg::FRAC{1'b0}}}
                  : (mrsp.res[zvj_pkg::VW-1] ? zvj_pkg::MW'(-mrsp.res)
                                              : zvj_pkg::MW'(mrsp.res));
  end

  assign in_i.ready  = state_q == S_IDLE;
  assign out_o.valid = ov_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      run_q   <= 1'b0;
      ov_q    <= 1'b0;
      t_q     <= '0;
      ac_q    <= '0;
      k_q     <= '0;
    end else begin
      // a new word from the finish step takes the place of the one just taken
      if (ov_q && out_o.ready && !(state_q == S_FIN && fin_go)) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            if (in_i.data.kind == zvj_pkg::KIND_START) begin
              tgt_q   <= in_i.data.target_accel;
              p0_q    <= in_i.data.start_position;
              v0_q    <= in_i.data.start_velocity;
              a0_q    <= in_i.data.start_accel;
              state_q <= S_SDIV;
            end else if (run_q) begin
              state_q <= S_TCHK;
            end
          end
        end
        S_SDIV: begin
          if (!pend_q) pend_q <= 1'b1;
          else if (drsp.done) begin
            pend_q  <= 1'b0;
            delta_q <= delta_n;
            state_q <= S_SMUL;
          end
        end
        S_SMUL: begin
          if (!pend_q) pend_q <= 1'b1;
          else if (mrsp.done) begin
            pend_q  <= 1'b0;
            tim_q   <= tim_n;
            jrk_q   <= jrk_n;
            end_q   <= (tgt_q == '0) ? zvj_pkg::ZERO_SPAN : end_n;
            t_q     <= '0;
            ac_q    <= '0;
            run_q   <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_TCHK: begin
          // at most one new impulse per sample
          if (ac_q < 3'd4 && t_q >= tim_rd) ac_q <= ac_q + 3'd1;
          jsum_q  <= '0;
          asum_q  <= zvj_pkg::AW'(a0_q);
          vsum_q  <= zvj_pkg::AW'(v0_q);
          psum_q  <= zvj_pkg::AW'(p0_q);
          state_q <= S_MAT;
        end
        S_MAT: begin
          if (!pend_q) pend_q <= 1'b1;
          else if (mrsp.done) begin
            pend_q  <= 1'b0;
            at_q    <= mrsp.res;
            vsum_q  <= vsum_q + zvj_pkg::AW'(mrsp.res);
            state_q <= S_MVT;
          end
        end
        S_MVT: begin
          if (!pend_q) pend_q <= 1'b1;
          else if (mrsp.done) begin
            pend_q  <= 1'b0;
            psum_q  <= psum_q + zvj_pkg::AW'(mrsp.res);
            state_q <= S_MATT;
          end
        end
        S_MATT: begin
          if (!pend_q) pend_q <= 1'b1;
          else if (mrsp.done) begin
            pend_q  <= 1'b0;
            psum_q  <= psum_q + zvj_pkg::AW'(mhalf);
            k_q     <= '0;
            state_q <= (ac_q == '0) ? S_FIN : S_KJA;
          end
        end
        S_KJA: begin
          if (!pend_q) pend_q <= 1'b1;
          else if (mrsp.done) begin
            pend_q  <= 1'b0;
            ja_q    <= mrsp.res;
            asum_q  <= asum_q + zvj_pkg::AW'(mrsp.res);
            jsum_q  <= jsum_q + zvj_pkg::AW'(jrk_rd);
            state_q <= S_KJV;
          end
        end
        S_KJV: begin
          if (!pend_q) pend_q <= 1'b1;
          else if (mrsp.done) begin
            pend_q  <= 1'b0;
            jv_q    <= mhalf;
            vsum_q  <= vsum_q + zvj_pkg::AW'(mhalf);
            state_q <= S_KJP;
          end
        end
        S_KJP: begin
          // divider starts on the product; pend stays set through the divide
          if (!pend_q) pend_q <= 1'b1;
          else if (mrsp.done) begin
            d3neg_q <= mrsp.res[zvj_pkg::VW-1];
            state_q <= S_KD3;
          end
        end
        S_KD3: begin
          if (drsp.done) begin
            pend_q <= 1'b0;
            psum_q <= psum_q + q3;
            if ({1'b0, k_q} + 3'd1 == ac_q) begin
              state_q <= S_FIN;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= S_KJA;
            end
          end
        end
        S_FIN: begin
          if (fin_go) begin
            out_q.sample_time  <= t_q;
            out_q.jerk_out     <= zvj_pkg::sat32(jsum_q);
            out_q.accel_out    <= zvj_pkg::sat32(asum_q);
            out_q.velocity_out <= zvj_pkg::sat32(vsum_q);
            out_q.position_out <= zvj_pkg::sat32(psum_q);
            out_q.done_res     <= done_now;
            ov_q               <= 1'b1;
            if (done_now) run_q <= 1'b0;
            else          t_q   <= t_next;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_ac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ac_q <= 3'd4)
    else $error("active impulse count above four");

  a_ac_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ac_q != $past(ac_q)) |-> (ac_q == $past(ac_q) + 3'd1 || ac_q == 3'd0))
    else $error("active impulse count jumped");

  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && fin_go && done_now) |=> !run_q)
    else $error("primitive still running after its last sample");

  a_word_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q) == S_FIN)
    else $error("result word raised outside the finish step");

endmodule

`default_nettype wire

>>> hw/rtl/zvj_mul.sv
// Shared Q16.16 multiplier: 48 x 32 magnitude product over two 24 x 32 passes,
// shift by 16, saturate at 2^47-1, restore sign. Depends on zvj_pkg.
`default_nettype none

module zvj_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire zvj_pkg::mul_req_t req_i,
  output      zvj_pkg::mul_rsp_t rsp_o
);

  localparam logic [zvj_pkg::PW-1:0] RND = zvj_pkg::PW'(1) << (zvj_pkg::FRAC - 1);

  logic [zvj_pkg::MW-1:0]         ua_q;
  logic [zvj_pkg::QW-1:0]         ub_q;
  logic [zvj_pkg::PW-1:0]         p_q;
  logic                           neg_q, busy_q, ph_q, done_q;

  logic [zvj_pkg::MW-1:0]         ua;
  logic [zvj_pkg::QW-1:0]         ub;
  logic [zvj_pkg::HW-1:0]         opa;
  logic [zvj_pkg::HW+zvj_pkg::QW-1:0] pp;
  logic [zvj_pkg::PW-1:0]         p_d;
  logic [zvj_pkg::MW-2:0]         mag;
  logic                           sat;

  always_comb begin
    ua  = req_i.a[zvj_pkg::VW-1] ? zvj_pkg::MW'(-req_i.a) : zvj_pkg::MW'(req_i.a);
    ub  = req_i.b[zvj_pkg::BW-1] ? zvj_pkg::QW'(-req_i.b) : zvj_pkg::QW'(req_i.b);
    opa = ph_q ? ua_q[zvj_pkg::MW-1:zvj_pkg::HW] : ua_q[zvj_pkg::HW-1:0];
    pp  = opa * ub_q;
    p_d = ph_q ? p_q + (zvj_pkg::PW'(pp) << zvj_pkg::HW) : p_q + zvj_pkg::PW'(pp);
    // anything at or above bit 63 of the product overflows the 47-bit term
    sat = |p_q[zvj_pkg::PW-1:zvj_pkg::MW+zvj_pkg::FRAC-1];
    mag = sat ? zvj_pkg::TERM_MAX : p_q[zvj_pkg::MW+zvj_pkg::FRAC-2:zvj_pkg::FRAC];
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = neg_q ? -$signed({2'b00, mag}) : $signed({2'b00, mag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        ph_q   <= 1'b0;
      end else if (busy_q) begin
        if (ph_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          ph_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ua_q  <= ua;
      ub_q  <= ub;
      neg_q <= req_i.a[zvj_pkg::VW-1] != req_i.b[zvj_pkg::BW-1];
      p_q   <= req_i.round ? RND : '0;
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/zvj_div.sv
// Shared restoring divider: one quotient bit a cycle for a general divisor,
// eight bits a cycle in divide-by-three mode. Depends on zvj_pkg.
`default_nettype none

module zvj_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire zvj_pkg::div_req_t req_i,
  output      zvj_pkg::div_rsp_t rsp_o
);

  localparam int unsigned STEP3 = 8;
  localparam int unsigned CNTW  = $clog2(zvj_pkg::MW + 1);
  localparam logic [2:0]  DIV3  = 3'd3;

  logic [zvj_pkg::MW-1:0] n_q, n_d;
  logic [zvj_pkg::TW-1:0] r_q, r_d, dv_q;
  logic                   div3_q, busy_q, done_q;
  logic [CNTW-1:0]        cnt_q;

  always_comb begin
    logic [zvj_pkg::TW:0] r2;
    logic [2:0]           r3;
    logic                 b;
    n_d = n_q;
    r_d = r_q;
    r2  = '0;
    r3  = '0;
    b   = 1'b0;
    if (div3_q) begin
      for (int i = 0; i < STEP3; i++) begin
        r3  = {r_d[1:0], n_d[zvj_pkg::MW-1]};
        b   = r3 >= DIV3;
        r3  = b ? r3 - DIV3 : r3;
        r_d = zvj_pkg::TW'(r3[1:0]);
        n_d = {n_d[zvj_pkg::MW-2:0], b};
      end
    end else begin
      r2  = {r_q, n_q[zvj_pkg::MW-1]};
      b   = r2 >= {1'b0, dv_q};
      r2  = b ? r2 - {1'b0, dv_q} : r2;
      r_d = r2[zvj_pkg::TW-1:0];
      n_d = {n_q[zvj_pkg::MW-2:0], b};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.div3 ? CNTW'(zvj_pkg::MW / STEP3) : CNTW'(zvj_pkg::MW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q    <= req_i.dividend;
      r_q    <= '0;
      dv_q   <= req_i.divisor;
      div3_q <= req_i.div3;
    end else if (busy_q) begin
      n_q <= n_d;
      r_q <= r_d;
    end
  end

endmodule

`default_nettype wire
